@@ sv/rlpenc_pkg.sv @@
`default_nettype none

package rlpenc_pkg;

   localparam int VALUE_BITS = 256;
   localparam int COUNT_BITS = 6;

   localparam logic [1:0] CMD_LEN_HEADER  = 2'd0;
   localparam logic [1:0] CMD_STR_START   = 2'd1;
   localparam logic [1:0] CMD_PAYLOAD     = 2'd2;
   localparam logic [1:0] CMD_INTEGER     = 2'd3;

   localparam logic [63:0] RLP_SHORT_LIMIT      = 64'd56;
   localparam logic [7:0]  RLP_STRING_BASE      = 8'h80;
   localparam logic [7:0]  RLP_LONG_STRING_BASE = 8'hB7;
   localparam logic [7:0]  RLP_SINGLE_LIMIT     = 8'h80;

   localparam logic [COUNT_BITS-1:0] LENGTH_BYTES  = 6'd8;
   localparam logic [COUNT_BITS-1:0] INTEGER_BYTES = 6'd32;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] length;
      logic [7:0]  data_byte;
      logic [63:0] value_limb0;
      logic [63:0] value_limb1;
      logic [63:0] value_limb2;
      logic [63:0] value_limb3;
   } rlpenc_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rlpenc_rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } rlpenc_shift_ctrl_type;

   typedef struct packed {
      logic [7:0]            top_byte;
      logic [COUNT_BITS-1:0] count;
   } rlpenc_shift_stat_type;

endpackage

`default_nettype wire

@@ sv/rlpenc_byte_shifter.sv @@
`default_nettype none

module rlpenc_byte_shifter
   import rlpenc_pkg::*;
(
   input  logic                  clock,
   input  rlpenc_shift_ctrl_type ctrl,
   input  logic [VALUE_BITS-1:0] load_value,
   input  logic [COUNT_BITS-1:0] load_count,
   output rlpenc_shift_stat_type stat
);

   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   // The value is kept left aligned so the next byte out is always the top byte.
   always_comb begin
      val_in = val_ff;
      cnt_in = cnt_ff;
      if (ctrl.load) begin
         val_in = load_value;
         cnt_in = load_count;
      end else if (ctrl.shift) begin
         val_in = {val_ff[VALUE_BITS-9:0], 8'h00};
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      cnt_ff <= cnt_in;
   end

   assign stat.top_byte = val_ff[VALUE_BITS-1:VALUE_BITS-8];
   assign stat.count    = cnt_ff;

endmodule

`default_nettype wire

@@ sv/rlp_item_encoder_top.sv @@
`default_nettype none

// Channel   Direction  Payload           Transfer when
// req_      in         rlpenc_req_type   req_valid && req_ready
// rsp_      out        rlpenc_rsp_type   rsp_valid && rsp_ready
//
// One item is taken at a time; req_ready is high only while the sequencer is idle.
// Payload bytes and short headers: the byte is held in byte_ff, then registered to the output.
// Long headers and integers go through a byte shifter that drops leading zero bytes one per
// cycle (up to 7 for a length, 31 for an integer), then emits one byte per cycle while the
// output is free: a header byte, then the value bytes (an integer below 0x80 goes out alone).
// Reset clears the sequencer and the output valid; rsp_ready low stalls a pending result.

module rlp_item_encoder_top
   import rlpenc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rlpenc_req_type req_payload,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rlpenc_rsp_type rsp_payload
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_HEAD = 3'd2;
   localparam logic [2:0] ST_BODY = 3'd3;
   localparam logic [2:0] ST_ONE  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  is_int_ff, is_int_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rlpenc_rsp_type        rsp_payload_ff, rsp_payload_in;

   rlpenc_shift_ctrl_type shift_ctrl;
   rlpenc_shift_stat_type shift_stat;
   logic [VALUE_BITS-1:0] load_value;
   logic [COUNT_BITS-1:0] load_count;

   logic req_fire;
   logic out_free;
   logic len_short;
   logic str_skip;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign len_short = (req_payload.length < RLP_SHORT_LIMIT);
   // A single-byte string below 0x80 is its own encoding, so it has no header.
   assign str_skip  = (req_payload.command == CMD_STR_START) &&
                      (req_payload.length == 64'd1) &&
                      (req_payload.data_byte < RLP_SINGLE_LIMIT);

   always_comb begin
      if (req_payload.command == CMD_INTEGER) begin
         load_value = {req_payload.value_limb3, req_payload.value_limb2,
                       req_payload.value_limb1, req_payload.value_limb0};
         load_count = INTEGER_BYTES;
      end else begin
         load_value = {req_payload.length, {(VALUE_BITS-64){1'b0}}};
         load_count = LENGTH_BYTES;
      end
   end

   always_comb begin
      state_in         = state_ff;
      is_int_in        = is_int_ff;
      byte_in          = byte_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_payload_in   = rsp_payload_ff;
      shift_ctrl.load  = 1'b0;
      shift_ctrl.shift = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_payload.command)
                  CMD_PAYLOAD: begin
                     byte_in  = req_payload.data_byte;
                     state_in = ST_ONE;
                  end
                  CMD_INTEGER: begin
                     shift_ctrl.load = 1'b1;
                     is_int_in       = 1'b1;
                     state_in        = ST_SCAN;
                  end
                  default: begin
                     if (!str_skip) begin
                        if (len_short) begin
                           byte_in  = RLP_STRING_BASE + {2'b00, req_payload.length[5:0]};
                           state_in = ST_ONE;
                        end else begin
                           shift_ctrl.load = 1'b1;
                           is_int_in       = 1'b0;
                           state_in        = ST_SCAN;
                        end
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if ((shift_stat.count > 6'd1) && (shift_stat.top_byte == 8'h00)) begin
               shift_ctrl.shift = 1'b1;
            end else if (is_int_ff && (shift_stat.count == 6'd1) &&
                         (shift_stat.top_byte < RLP_SINGLE_LIMIT)) begin
               // Zero encodes as the empty string; other small values as themselves.
               byte_in  = (shift_stat.top_byte == 8'h00) ? RLP_STRING_BASE
                                                         : shift_stat.top_byte;
               state_in = ST_ONE;
            end else begin
               byte_in  = (is_int_ff ? RLP_STRING_BASE : RLP_LONG_STRING_BASE) +
                          {2'b00, shift_stat.count};
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.out_byte  = byte_ff;
               rsp_payload_in.last_byte = 1'b0;
               state_in                 = ST_BODY;
            end
         end
         ST_BODY: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.out_byte  = shift_stat.top_byte;
               rsp_payload_in.last_byte = (shift_stat.count == 6'd1);
               shift_ctrl.shift         = 1'b1;
               if (shift_stat.count == 6'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ONE: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.out_byte  = byte_ff;
               rsp_payload_in.last_byte = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_int_ff      <= is_int_in;
      byte_ff        <= byte_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   rlpenc_byte_shifter u_shifter (
      .clock      (clock),
      .ctrl       (shift_ctrl),
      .load_value (load_value),
      .load_count (load_count),
      .stat       (shift_stat)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

@@ sv/rlpenc_checker.sv @@
`default_nettype none

module rlpenc_checker
   import rlpenc_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           req_valid,
   input logic           req_ready,
   input rlpenc_req_type req_payload,
   input logic           rsp_valid,
   input logic           rsp_ready,
   input rlpenc_rsp_type rsp_payload
);

   // A result that is not taken stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Every command but a string start always produces bytes, so the block goes busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_payload.command != CMD_STR_START) |=> !req_ready)
      else $error("ready after accepting an item that yields output");

   // Bytes of one item follow without gaps when the consumer keeps up.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_byte |=> rsp_valid)
      else $error("gap inside the bytes of one item");

endmodule

bind rlp_item_encoder_top rlpenc_checker u_rlpenc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

@@ test/tb_rlp_item_encoder_top.sv @@
`default_nettype none

module tb_rlp_item_encoder_top;
   import rlpenc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int RANDOM_PER_PHASE = 19;

   // Predicts the encoded byte stream of each accepted item and checks the
   // bytes coming back from the block against it in order.
   class encoded_byte_tracker;
      rlpenc_rsp_type pending_bytes[$];
      logic [7:0]     item_bytes[$];
      int             mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      function void push_length_bytes(logic [63:0] len);
         int nbytes;
         nbytes = 1;
         if (len < RLP_SHORT_LIMIT) begin
            item_bytes.push_back(RLP_STRING_BASE + len[7:0]);
         end else begin
            while (nbytes < 8 && (len >> (8 * nbytes)) != 64'd0) nbytes++;
            item_bytes.push_back(RLP_LONG_STRING_BASE + 8'(nbytes));
            for (int i = nbytes - 1; i >= 0; i--) item_bytes.push_back(len[8*i +: 8]);
         end
      endfunction

      function void encode_integer(logic [255:0] value);
         int nbytes;
         nbytes = 32;
         while (nbytes > 0 && value[8*nbytes-1 -: 8] == 8'd0) nbytes--;
         if (nbytes == 0) begin
            item_bytes.push_back(RLP_STRING_BASE);
         end else if (nbytes == 1 && value[7:0] < RLP_SINGLE_LIMIT) begin
            item_bytes.push_back(value[7:0]);
         end else begin
            item_bytes.push_back(RLP_STRING_BASE + 8'(nbytes));
            for (int i = nbytes - 1; i >= 0; i--) item_bytes.push_back(value[8*i +: 8]);
         end
      endfunction

      function void note_item(rlpenc_req_type item);
         rlpenc_rsp_type entry;
         item_bytes.delete();
         case (item.command)
            CMD_LEN_HEADER: begin
               push_length_bytes(item.length);
            end
            CMD_STR_START: begin
               // A lone byte below 0x80 is its own encoding, so no header.
               if (item.length != 64'd1 || item.data_byte >= RLP_SINGLE_LIMIT)
                  push_length_bytes(item.length);
            end
            CMD_PAYLOAD: begin
               item_bytes.push_back(item.data_byte);
            end
            default: begin
               encode_integer({item.value_limb3, item.value_limb2,
                               item.value_limb1, item.value_limb0});
            end
         endcase
         foreach (item_bytes[i]) begin
            entry.out_byte  = item_bytes[i];
            entry.last_byte = (i == item_bytes.size() - 1);
            pending_bytes.push_back(entry);
         end
      endfunction

      function void check_byte(rlpenc_rsp_type got);
         rlpenc_rsp_type want;
         if (pending_bytes.size() == 0) begin
            $error("unexpected transfer: out_byte=%02h last_byte=%0b",
                   got.out_byte, got.last_byte);
            mismatch_count++;
            return;
         end
         want = pending_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
            mismatch_count++;
         end
         if (got.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, actual %0b", want.last_byte, got.last_byte);
            mismatch_count++;
         end
      endfunction
   endclass

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   rlpenc_req_type req_payload;
   logic           rsp_valid;
   logic           rsp_ready;
   rlpenc_rsp_type rsp_payload;

   int send_idle_pct = 0;
   int stall_pct     = 0;

   encoded_byte_tracker tracker = new();

   rlp_item_encoder_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_byte(rsp_payload);
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_rlp_item_encoder_top: done, errors");
      $finish;
   end

   // Value of exactly nbytes significant bytes: the top one is never zero.
   function automatic logic [255:0] random_wide(int nbytes);
      logic [255:0] v;
      for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
      if (nbytes < 32) v &= (256'd1 << (8 * nbytes)) - 256'd1;
      if (nbytes > 0 && v[8*nbytes-1 -: 8] == 8'd0)
         v[8*nbytes-1 -: 8] = 8'($urandom_range(1, 255));
      return v;
   endfunction

   // Fields that the command ignores are filled with random bits.
   function automatic rlpenc_req_type make_item(logic [1:0] cmd, logic [63:0] len,
                                                logic [7:0] db, logic [255:0] value);
      rlpenc_req_type item;
      item.command   = cmd;
      item.length    = (cmd == CMD_LEN_HEADER || cmd == CMD_STR_START) ?
                       len : {$urandom, $urandom};
      item.data_byte = (cmd == CMD_STR_START || cmd == CMD_PAYLOAD) ? db : 8'($urandom);
      {item.value_limb3, item.value_limb2, item.value_limb1, item.value_limb0} =
         (cmd == CMD_INTEGER) ? value : random_wide(32);
      return item;
   endfunction

   function automatic logic [63:0] random_length();
      if ($urandom_range(3) == 0) return 64'($urandom_range(50, 60));
      return 64'(random_wide($urandom_range(0, 8)));
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(rlpenc_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      tracker.note_item(item);
      @(negedge clock);
   endtask

   task automatic run_directed();
      logic [63:0]  header_lengths[6] = '{64'd0, 64'd55, 64'd56, 64'd256,
                                          64'h0100_0000_0000_0000,
                                          64'hFFFF_FFFF_FFFF_FFFF};
      logic [255:0] integers[10] = '{256'd0, 256'd1, 256'h7F, 256'h80, 256'hFF,
                                     256'h100, 256'd1 << 64, 256'd1 << 192,
                                     256'd1 << 255, {256{1'b1}}};
      foreach (header_lengths[i])
         send_item(make_item(CMD_LEN_HEADER, header_lengths[i], 8'h00, '0));
      // Single-byte strings on both sides of 0x80, then empty and long ones.
      send_item(make_item(CMD_STR_START, 64'd1, 8'h00, '0));
      send_item(make_item(CMD_STR_START, 64'd1, 8'h7F, '0));
      send_item(make_item(CMD_STR_START, 64'd1, 8'h80, '0));
      send_item(make_item(CMD_STR_START, 64'd1, 8'hFF, '0));
      send_item(make_item(CMD_STR_START, 64'd0, 8'h55, '0));
      send_item(make_item(CMD_STR_START, 64'd56, 8'h00, '0));
      send_item(make_item(CMD_PAYLOAD, '0, 8'h00, '0));
      send_item(make_item(CMD_PAYLOAD, '0, 8'hFF, '0));
      foreach (integers[i])
         send_item(make_item(CMD_INTEGER, '0, 8'h00, integers[i]));
   endtask

   task automatic send_random_items(int count);
      int          sent;
      int          choice;
      int          body;
      logic [63:0] len;
      logic [7:0]  first;
      rlpenc_req_type noise;
      sent = 0;
      while (sent < count) begin
         choice = $urandom_range(99);
         if (choice < 45) begin
            // A string: its start followed by the payload bytes. Long ones
            // are cut short, which the block does not track anyway.
            first = 8'($urandom);
            if ($urandom_range(9) < 7) begin
               len  = 64'($urandom_range(0, 4));
               body = int'(len);
               if (len == 64'd1 && $urandom_range(1)) first = 8'($urandom_range(0, 127));
            end else begin
               len  = random_length();
               body = $urandom_range(0, 2);
            end
            send_item(make_item(CMD_STR_START, len, first, '0));
            sent++;
            for (int k = 0; k < body; k++) begin
               send_item(make_item(CMD_PAYLOAD, '0, (k == 0) ? first : 8'($urandom), '0));
               sent++;
            end
         end else if (choice < 57) begin
            send_item(make_item(CMD_LEN_HEADER, random_length(), 8'h00, '0));
            sent++;
         end else if (choice < 65) begin
            send_item(make_item(CMD_PAYLOAD, '0, 8'($urandom), '0));
            sent++;
         end else if (choice < 88) begin
            send_item(make_item(CMD_INTEGER, '0, 8'h00, random_wide($urandom_range(0, 32))));
            sent++;
         end else begin
            noise = make_item(2'($urandom), {$urandom, $urandom}, 8'($urandom),
                              random_wide(32));
            send_item(noise);
            sent++;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 73;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 73;
            end
            default: begin
               send_idle_pct = 26;
               stall_pct     = 26;
            end
         endcase
         if (phase == 0) run_directed();
         send_random_items(RANDOM_PER_PHASE);
      end
      req_valid <= 1'b0;

      while (tracker.pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatch_count == 0 && tracker.pending_bytes.size() == 0)
         $display("tb_rlp_item_encoder_top: done, clean");
      else
         $display("tb_rlp_item_encoder_top: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
